// ----- sv/ctp_pkg.sv -----
// Package with shared types, codes and defaults for the call time profiler.
package ctp_pkg;

   localparam int STACK_DEPTH_DEF   = 64;
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int TRACE_DEPTH_DEF   = 1024;
   localparam int TIME_BITS_DEF     = 48;
   localparam logic [10:0] TRACE_LIMIT_RESET = 11'd1024;

   typedef enum logic [2:0] {
      FUNC_START = 3'd0,
      FUNC_STOP  = 3'd1,
      FUNC_ENTER = 3'd2,
      FUNC_EXIT  = 3'd3,
      FUNC_RDTAB = 3'd4,
      FUNC_RDTRC = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_STACK = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FRAME,
      S_SEARCH,
      S_CHECK,
      S_UPDATE,
      S_READ,
      S_READ2,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic do_start;
      logic do_stop;
      logic do_enter;
      logic rd_frame;
      logic exit_calc;
      logic scan_rd;
      logic scan_next;
      logic update;
      logic rd_out;
      logic rd_latch;
      logic respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     stack_empty;
      logic     stack_full;
      logic     active;
      logic     scan_done;
      logic     scan_hit;
   } stat_type;

endpackage

// ----- sv/ctp_ram.sv -----
// Generic simple dual port RAM (one write port, one read port) with registered read data.
module ctp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- sv/ctp_ctrl.sv -----
// Controller state machine for the call time profiler.
module ctp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ctp_pkg::stat_type stat,
   output ctp_pkg::cmd_type  cmd
);

   ctp_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ctp_pkg::S_IDLE);
      unique case (state_ff)
         ctp_pkg::S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ctp_pkg::S_DECODE;
            end
         end
         ctp_pkg::S_DECODE: begin
            unique case (stat.func)
               ctp_pkg::FUNC_START: begin
                  cmd.do_start = 1'b1;
                  state_in     = ctp_pkg::S_DONE;
               end
               ctp_pkg::FUNC_STOP: begin
                  cmd.do_stop = 1'b1;
                  state_in    = ctp_pkg::S_DONE;
               end
               ctp_pkg::FUNC_ENTER: begin
                  cmd.do_enter = 1'b1;
                  state_in     = ctp_pkg::S_DONE;
               end
               ctp_pkg::FUNC_EXIT: begin
                  if (stat.stack_empty) begin
                     state_in = ctp_pkg::S_DONE;
                  end else begin
                     cmd.rd_frame = 1'b1;
                     state_in     = ctp_pkg::S_FRAME;
                  end
               end
               ctp_pkg::FUNC_RDTAB, ctp_pkg::FUNC_RDTRC: begin
                  cmd.rd_out = 1'b1;
                  state_in   = ctp_pkg::S_READ;
               end
               default: state_in = ctp_pkg::S_DONE;
            endcase
         end
         ctp_pkg::S_FRAME: begin
            cmd.exit_calc = 1'b1;
            cmd.scan_rd   = 1'b1;
            state_in      = ctp_pkg::S_SEARCH;
         end
         ctp_pkg::S_SEARCH: begin
            // Slot read is in flight; compare next cycle.
            state_in = ctp_pkg::S_CHECK;
         end
         ctp_pkg::S_CHECK: begin
            if (stat.scan_hit || stat.scan_done) begin
               state_in = ctp_pkg::S_UPDATE;
            end else begin
               cmd.scan_next = 1'b1;
               cmd.scan_rd   = 1'b1;
               state_in      = ctp_pkg::S_SEARCH;
            end
         end
         ctp_pkg::S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ctp_pkg::S_DONE;
         end
         ctp_pkg::S_READ: begin
            state_in = ctp_pkg::S_READ2;
         end
         ctp_pkg::S_READ2: begin
            cmd.rd_latch = 1'b1;
            state_in     = ctp_pkg::S_DONE;
         end
         ctp_pkg::S_DONE: begin
            cmd.respond = 1'b1;
            state_in    = ctp_pkg::S_IDLE;
         end
         default: state_in = ctp_pkg::S_IDLE;
      endcase
   end

   // A response is given only on the way back to idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> state_ff == ctp_pkg::S_IDLE)
      else $error("response not followed by idle");
   // A table update follows a finished or hitting scan.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(stat.scan_hit || stat.scan_done))
      else $error("update without finished scan");
   // Items are taken only while idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !busy)
      else $error("capture while busy");

endmodule

// ----- sv/ctp_dp.sv -----
// Datapath of the call time profiler: stack, key table, trace store and sums.
module ctp_dp #(
   parameter int STACK_DEPTH   = ctp_pkg::STACK_DEPTH_DEF,
   parameter int TABLE_ENTRIES = ctp_pkg::TABLE_ENTRIES_DEF,
   parameter int TRACE_DEPTH   = ctp_pkg::TRACE_DEPTH_DEF,
   parameter int TIME_BITS     = ctp_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctp_pkg::cmd_type     cmd,
   output ctp_pkg::stat_type    stat,
   input  logic [10:0]          trace_limit,
   input  logic [2:0]           req_func,
   input  logic [TIME_BITS-1:0] req_timestamp_ns,
   input  logic [15:0]          req_call_key,
   input  logic [9:0]           req_read_index,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic                 rsp_active,
   output logic [6:0]           rsp_nest_depth,
   output logic [15:0]          rsp_entry_key,
   output logic [31:0]          rsp_call_count,
   output logic [TIME_BITS-1:0] rsp_inclusive_ns,
   output logic [TIME_BITS-1:0] rsp_self_ns,
   output logic [TIME_BITS-1:0] rsp_trace_start_ns,
   output logic [TIME_BITS-1:0] rsp_trace_duration_ns,
   output logic [31:0]          rsp_dropped_count
);

   localparam int SA = $clog2(STACK_DEPTH);
   localparam int TA = $clog2(TABLE_ENTRIES);
   localparam int RA = $clog2(TRACE_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH + 1);
   localparam int TW = $clog2(TABLE_ENTRIES + 1);
   localparam int RW = $clog2(TRACE_DEPTH + 1);
   localparam int SLW = 16 + 32 + 2 * TIME_BITS;
   localparam int RCW = 16 + 7 + 2 * TIME_BITS;
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   // Captured item.
   logic [2:0]           func_ff;
   logic [TIME_BITS-1:0] ts_ff;
   logic [15:0]          key_ff;
   logic [9:0]           ridx_ff;

   // Control state.
   logic                 on_ff;
   logic [TIME_BITS-1:0] start_time_ff;
   logic [SW-1:0]        sp_ff;
   logic [TW-1:0]        used_ff;
   logic [RW-1:0]        rec_ff;
   logic [31:0]          drop_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TW-1:0]        scan_ff;

   // Exit working values.
   logic [TIME_BITS-1:0] incl_ff, self_ff, rel_ff;

   // Result registers.
   logic                 rsp_valid_ff;
   logic [1:0]           status_ff;
   logic [6:0]           depth_ff;
   logic [15:0]          ekey_ff;
   logic [31:0]          cnt_ff;
   logic [TIME_BITS-1:0] oincl_ff, oself_ff, ostart_ff, odur_ff;

   // Stack memories: entry time and child time.
   logic                 fe_we, fc_we;
   logic [SA-1:0]        fe_wa, fc_wa, f_ra;
   logic [TIME_BITS-1:0] fe_wd, fc_wd, fe_rd, fc_rd;
   logic                 child_pend_ff;
   logic [SA-1:0]        child_addr_ff;
   logic [TIME_BITS-1:0] child_add_ff;

   // Slot and record memories.
   logic                 sl_we;
   logic [TA-1:0]        sl_wa, sl_ra;
   logic [SLW-1:0]       sl_wd, sl_rd;
   logic                 rc_we;
   logic [RA-1:0]        rc_wa, rc_ra;
   logic [RCW-1:0]       rc_wd, rc_rd;

   ctp_ram #(.WIDTH(TIME_BITS), .DEPTH(STACK_DEPTH)) u_fentry (
      .clock, .wr_en(fe_we), .wr_addr(fe_wa), .wr_data(fe_wd),
      .rd_addr(f_ra), .rd_data(fe_rd));
   ctp_ram #(.WIDTH(TIME_BITS), .DEPTH(STACK_DEPTH)) u_fchild (
      .clock, .wr_en(fc_we), .wr_addr(fc_wa), .wr_data(fc_wd),
      .rd_addr(f_ra), .rd_data(fc_rd));
   ctp_ram #(.WIDTH(SLW), .DEPTH(TABLE_ENTRIES)) u_slot (
      .clock, .wr_en(sl_we), .wr_addr(sl_wa), .wr_data(sl_wd),
      .rd_addr(sl_ra), .rd_data(sl_rd));
   ctp_ram #(.WIDTH(RCW), .DEPTH(TRACE_DEPTH)) u_rec (
      .clock, .wr_en(rc_we), .wr_addr(rc_wa), .wr_data(rc_wd),
      .rd_addr(rc_ra), .rd_data(rc_rd));

   // Slot fields from the read port.
   logic [15:0]          s_key;
   logic [31:0]          s_cnt;
   logic [TIME_BITS-1:0] s_incl, s_self;
   assign {s_key, s_cnt, s_incl, s_self} = sl_rd;

   // Exit arithmetic.
   logic [TIME_BITS-1:0] incl_c, self_c;
   logic [SW-1:0]        top;
   assign top    = sp_ff - SW'(1);
   assign incl_c = ts_ff - fe_rd;
   assign self_c = (incl_c > fc_rd) ? incl_c - fc_rd : '0;

   // Table hit and scan end.
   logic hit, scan_end, new_slot, found;
   assign hit      = valid_ff[scan_ff[TA-1:0]] && (s_key == key_ff);
   assign scan_end = (scan_ff + TW'(1) >= used_ff);
   assign new_slot = !hit && (used_ff < TW'(TABLE_ENTRIES));
   assign found    = hit || new_slot;

   // Saturated table sums.
   logic [31:0]          n_cnt;
   logic [TIME_BITS-1:0] n_incl, n_self;
   logic [TIME_BITS:0]   sum_i, sum_s, sum_c;
   always_comb begin
      sum_i  = {1'b0, hit ? s_incl : '0} + {1'b0, incl_ff};
      sum_s  = {1'b0, hit ? s_self : '0} + {1'b0, self_ff};
      sum_c  = {1'b0, child_pend_ff ? fc_rd : '0} + {1'b0, child_add_ff};
      n_incl = sum_i[TIME_BITS] ? TMAX : sum_i[TIME_BITS-1:0];
      n_self = sum_s[TIME_BITS] ? TMAX : sum_s[TIME_BITS-1:0];
      n_cnt  = !hit ? 32'd1 : ((s_cnt == '1) ? s_cnt : s_cnt + 32'd1);
   end

   // Trace cap.
   logic [RW:0] cap;
   assign cap = (32'(trace_limit) < TRACE_DEPTH) ? (RW+1)'(trace_limit)
                                                : (RW+1)'(TRACE_DEPTH);

   // Memory addressing.
   always_comb begin
      // Frame read: the popped frame on decode, then its parent for the child add.
      f_ra   = cmd.rd_frame ? top[SA-1:0] : child_addr_ff;
      fe_we  = cmd.do_enter && on_ff && (sp_ff < SW'(STACK_DEPTH));
      fe_wa  = sp_ff[SA-1:0];
      fe_wd  = ts_ff;
      // Child memory: clear on push, add into the parent frame on the table update after an exit.
      fc_we  = fe_we || (child_pend_ff && cmd.update);
      fc_wa  = fe_we ? sp_ff[SA-1:0] : child_addr_ff;
      fc_wd  = fe_we ? '0 : (sum_c[TIME_BITS] ? TMAX : sum_c[TIME_BITS-1:0]);
      // A table readout holds its slot address until the data is latched.
      if (cmd.rd_out || func_ff == ctp_pkg::FUNC_RDTAB) begin
         sl_ra = ridx_ff[TA-1:0];
      end else begin
         sl_ra = cmd.scan_next ? TA'(scan_ff + TW'(1)) : scan_ff[TA-1:0];
      end
      sl_we  = cmd.update && found;
      sl_wa  = hit ? scan_ff[TA-1:0] : used_ff[TA-1:0];
      sl_wd  = {key_ff, n_cnt, n_incl, n_self};
      rc_ra  = ridx_ff[RA-1:0];
      rc_we  = cmd.update && ((RW+1)'(rec_ff) < cap);
      rc_wa  = rec_ff[RA-1:0];
      rc_wd  = {key_ff, 7'(top), rel_ff, incl_ff};
   end

   // Readout qualification.
   logic tab_ok, trc_ok;
   assign tab_ok = (32'(ridx_ff) < TABLE_ENTRIES) && valid_ff[ridx_ff[TA-1:0]];
   assign trc_ok = (32'(ridx_ff) < 32'(rec_ff)) && (32'(ridx_ff) < TRACE_DEPTH);

   // Sequential datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff         <= 1'b0;
         start_time_ff <= '0;
         sp_ff         <= '0;
         used_ff       <= '0;
         rec_ff        <= '0;
         drop_ff       <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         child_pend_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.capture) begin
            func_ff   <= req_func;
            ts_ff     <= req_timestamp_ns;
            key_ff    <= req_call_key;
            ridx_ff   <= req_read_index;
            status_ff <= ctp_pkg::ST_OK;
            depth_ff  <= '0;
            ekey_ff   <= '0;
            cnt_ff    <= '0;
            oincl_ff  <= '0;
            oself_ff  <= '0;
            ostart_ff <= '0;
            odur_ff   <= '0;
            scan_ff   <= '0;
         end
         if (cmd.do_start) begin
            sp_ff         <= '0;
            used_ff       <= '0;
            rec_ff        <= '0;
            drop_ff       <= '0;
            valid_ff      <= '0;
            start_time_ff <= ts_ff;
            on_ff         <= 1'b1;
         end
         if (cmd.do_stop) begin
            on_ff <= 1'b0;
         end
         if (cmd.do_enter && on_ff) begin
            if (sp_ff >= SW'(STACK_DEPTH)) begin
               status_ff <= ctp_pkg::ST_STACK;
            end else begin
               depth_ff <= 7'(sp_ff);
               sp_ff    <= sp_ff + SW'(1);
            end
         end
         if (cmd.rd_frame && func_ff == ctp_pkg::FUNC_EXIT && sp_ff == '0) begin
            status_ff <= ctp_pkg::ST_STACK;
         end
         if (func_ff == ctp_pkg::FUNC_EXIT && sp_ff == '0 && !cmd.rd_frame
             && !cmd.capture && !cmd.respond && !rsp_valid_ff) begin
            status_ff <= ctp_pkg::ST_STACK;
         end
         if (cmd.exit_calc) begin
            incl_ff       <= incl_c;
            self_ff       <= self_c;
            rel_ff        <= fe_rd - start_time_ff;
            child_pend_ff <= (top != '0);
            child_addr_ff <= SA'(top - SW'(1));
            child_add_ff  <= incl_c;
         end
         if (cmd.scan_next) begin
            scan_ff <= scan_ff + TW'(1);
         end
         if (cmd.update) begin
            child_pend_ff <= 1'b0;
            sp_ff         <= top;
            depth_ff      <= 7'(top);
            ekey_ff       <= key_ff;
            ostart_ff     <= rel_ff;
            odur_ff       <= incl_ff;
            if (found) begin
               cnt_ff   <= n_cnt;
               oincl_ff <= n_incl;
               oself_ff <= n_self;
               if (!hit) begin
                  valid_ff[used_ff[TA-1:0]] <= 1'b1;
                  used_ff <= used_ff + TW'(1);
               end
            end else begin
               status_ff <= ctp_pkg::ST_FULL;
            end
            if ((RW+1)'(rec_ff) < cap) begin
               rec_ff <= rec_ff + RW'(1);
            end else if (drop_ff != '1) begin
               drop_ff <= drop_ff + 32'd1;
            end
         end
         if (cmd.rd_latch) begin
            if (func_ff == ctp_pkg::FUNC_RDTAB) begin
               if (tab_ok) begin
                  ekey_ff  <= s_key;
                  cnt_ff   <= s_cnt;
                  oincl_ff <= s_incl;
                  oself_ff <= s_self;
               end else begin
                  status_ff <= ctp_pkg::ST_EMPTY;
               end
            end else begin
               if (trc_ok) begin
                  {ekey_ff, depth_ff, ostart_ff, odur_ff} <= rc_rd;
               end else begin
                  status_ff <= ctp_pkg::ST_EMPTY;
               end
            end
         end
      end
   end

   // Status to the controller.
   assign stat.func        = ctp_pkg::func_type'(func_ff);
   assign stat.stack_empty = (sp_ff == '0);
   assign stat.stack_full  = (sp_ff >= SW'(STACK_DEPTH));
   assign stat.active      = on_ff;
   assign stat.scan_done   = scan_end || (used_ff == '0);
   assign stat.scan_hit    = hit && (used_ff != '0);

   // Result ports.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_active            = on_ff;
   assign rsp_nest_depth        = depth_ff;
   assign rsp_entry_key         = ekey_ff;
   assign rsp_call_count        = cnt_ff;
   assign rsp_inclusive_ns      = oincl_ff;
   assign rsp_self_ns           = oself_ff;
   assign rsp_trace_start_ns    = ostart_ff;
   assign rsp_trace_duration_ns = odur_ff;
   assign rsp_dropped_count     = drop_ff;

   // The stack pointer never passes its depth.
   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SW'(STACK_DEPTH))
      else $error("stack pointer out of range");
   // Slot count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= TW'(TABLE_ENTRIES))
      else $error("slot count out of range");
   // A table update moves the stack down by one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> sp_ff == $past(top))
      else $error("exit did not pop");

endmodule

// ----- sv/call_time_profiler_unit.sv -----
// Top level of the call time profiler: controller, datapath and trace limit register.
//
// Usage: drive req_func, req_timestamp_ns, req_call_key and req_read_index and
// raise start while busy is low; the item is taken at that edge. One result item
// per input item appears on the rsp_ ports for exactly one cycle with rsp_valid
// high; the receiver cannot stall, so it must take every result as it comes.
// Start, stop, enter, unused codes and an exit on an empty stack go from the decode
// state straight to the response state; readouts pass through S_READ and S_READ2;
// any other exit reads its stack frame, then scans the key table slots (1 up to
// slots in use), one slot per read of the table memory, before the table update.
// Items are handled one at a time; busy drops in the strobe cycle, so the next
// item can be taken there.
// The csr_ channel writes trace_limit (reset value 1024) when csr_valid and
// csr_ready are high; csr_ready is high while the block is idle.
// Reset (synchronous) stops profiling, empties the stack, table and trace and
// zeroes the drop count; no clearing pass is needed, slot valid bits reset at once.
// Stack, table and trace memories hold no defined data until written.
module call_time_profiler_unit #(
   parameter int STACK_DEPTH   = ctp_pkg::STACK_DEPTH_DEF,
   parameter int TABLE_ENTRIES = ctp_pkg::TABLE_ENTRIES_DEF,
   parameter int TRACE_DEPTH   = ctp_pkg::TRACE_DEPTH_DEF,
   parameter int TIME_BITS     = ctp_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_func,
   input  logic [TIME_BITS-1:0] req_timestamp_ns,
   input  logic [15:0]          req_call_key,
   input  logic [9:0]           req_read_index,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic                 rsp_active,
   output logic [6:0]           rsp_nest_depth,
   output logic [15:0]          rsp_entry_key,
   output logic [31:0]          rsp_call_count,
   output logic [TIME_BITS-1:0] rsp_inclusive_ns,
   output logic [TIME_BITS-1:0] rsp_self_ns,
   output logic [TIME_BITS-1:0] rsp_trace_start_ns,
   output logic [TIME_BITS-1:0] rsp_trace_duration_ns,
   output logic [31:0]          rsp_dropped_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [10:0]          csr_data
);

   ctp_pkg::cmd_type  cmd;
   ctp_pkg::stat_type stat;
   logic [10:0]       limit_ff;

   // Trace limit register.
   assign csr_ready = !busy;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ctp_pkg::TRACE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   ctp_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .stat, .cmd);

   ctp_dp #(
      .STACK_DEPTH(STACK_DEPTH), .TABLE_ENTRIES(TABLE_ENTRIES),
      .TRACE_DEPTH(TRACE_DEPTH), .TIME_BITS(TIME_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .stat, .trace_limit(limit_ff),
      .req_func, .req_timestamp_ns, .req_call_key, .req_read_index,
      .rsp_valid, .rsp_status, .rsp_active, .rsp_nest_depth, .rsp_entry_key,
      .rsp_call_count, .rsp_inclusive_ns, .rsp_self_ns, .rsp_trace_start_ns,
      .rsp_trace_duration_ns, .rsp_dropped_count);

endmodule

// ----- bench/tb_call_time_profiler_unit.sv -----
// Self-checking bench for the call time profiler: queued driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb_call_time_profiler_unit;

   localparam int          FRAMES       = 64;
   localparam int          SLOTS        = 256;
   localparam int          RECORDS      = 1024;
   localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
   localparam logic [2:0]  FUNC_SPARE_A = 3'd6;
   localparam logic [2:0]  FUNC_SPARE_B = 3'd7;
   localparam int          CYCLE_LIMIT  = 3000000;

   typedef struct {
      logic [2:0]  func;
      logic [47:0] stamp;
      logic [15:0] key;
      logic [9:0]  index;
      bit          hold;
   } event_item_type;

   typedef struct {
      ctp_pkg::status_type status;
      logic        active;
      logic [6:0]  depth;
      logic [15:0] key;
      logic [31:0] count;
      logic [47:0] incl;
      logic [47:0] self_t;
      logic [47:0] tstart;
      logic [47:0] tdur;
      logic [31:0] dropped;
   } profile_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_func = '0;
   logic [47:0] req_timestamp_ns = '0;
   logic [15:0] req_call_key = '0;
   logic [9:0]  req_read_index = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_active;
   logic [6:0]  rsp_nest_depth;
   logic [15:0] rsp_entry_key;
   logic [31:0] rsp_call_count;
   logic [47:0] rsp_inclusive_ns;
   logic [47:0] rsp_self_ns;
   logic [47:0] rsp_trace_start_ns;
   logic [47:0] rsp_trace_duration_ns;
   logic [31:0] rsp_dropped_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_data = '0;

   call_time_profiler_unit u_dut (.*);

   always #2 clock = ~clock;

   // Pending items, expected results and run bookkeeping.
   event_item_type     pending_events[$];
   profile_result_type expected_results[$];
   int                 gap_pct = 0;
   bit                 item_taken = 0;
   int                 mismatches = 0;
   int                 results_seen = 0;
   int                 cycles = 0;
   int                 exits_seen = 0;

   // Predictor state.
   logic [10:0] trace_cap_reg;
   bit          prof_on;
   logic [47:0] prof_t0;
   int          open_frames;
   logic [47:0] frame_entry[FRAMES];
   logic [47:0] frame_child[FRAMES];
   bit          slot_live[SLOTS];
   logic [15:0] slot_id[SLOTS];
   logic [31:0] slot_calls[SLOTS];
   logic [47:0] slot_incl[SLOTS];
   logic [47:0] slot_self[SLOTS];
   int          slots_taken;
   logic [15:0] rec_key[RECORDS];
   logic [6:0]  rec_depth[RECORDS];
   logic [47:0] rec_start[RECORDS];
   logic [47:0] rec_dur[RECORDS];
   int          recs_taken;
   logic [31:0] drops;

   function automatic logic [63:0] clamp_sum(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      return (a >= m || b > m - a) ? m : a + b;
   endfunction

   function automatic void clear_profile();
      open_frames = 0;
      slots_taken = 0;
      recs_taken = 0;
      drops = '0;
      foreach (slot_live[i]) slot_live[i] = 0;
   endfunction

   // Work out the one result of an accepted item and update the predicted state.
   function automatic void predict_profile(logic [2:0] f, logic [47:0] ts, logic [15:0] key,
                                           logic [9:0] idx);
      profile_result_type r;
      int              s;
      int              top;
      int              cap;
      bit              hit;
      logic [47:0]     ent;
      logic [47:0]     chd;
      logic [47:0]     incl;
      logic [47:0]     slf;
      r = '{ctp_pkg::ST_OK, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0};
      case (f)
         ctp_pkg::FUNC_START: begin
            clear_profile();
            prof_t0 = ts;
            prof_on = 1;
         end
         ctp_pkg::FUNC_STOP: prof_on = 0;
         ctp_pkg::FUNC_ENTER: begin
            if (prof_on) begin
               if (open_frames >= FRAMES) begin
                  r.status = ctp_pkg::ST_STACK;
               end else begin
                  frame_entry[open_frames] = ts;
                  frame_child[open_frames] = '0;
                  r.depth = 7'(open_frames);
                  open_frames++;
               end
            end
         end
         ctp_pkg::FUNC_EXIT: begin
            if (open_frames == 0) begin
               r.status = ctp_pkg::ST_STACK;
            end else begin
               exits_seen++;
               top = open_frames - 1;
               ent = frame_entry[top];
               chd = frame_child[top];
               incl = ts - ent;
               slf = (incl > chd) ? incl - chd : '0;
               open_frames = top;
               if (top > 0)
                  frame_child[top-1] = 48'(clamp_sum(frame_child[top-1], incl, TIME_MAX));
               hit = 0;
               for (s = 0; s < slots_taken; s++) begin
                  if (slot_live[s] && slot_id[s] == key) begin
                     hit = 1;
                     break;
                  end
               end
               if (!hit && slots_taken < SLOTS) begin
                  s = slots_taken;
                  slot_live[s] = 1;
                  slot_id[s] = key;
                  slot_calls[s] = '0;
                  slot_incl[s] = '0;
                  slot_self[s] = '0;
                  slots_taken++;
                  hit = 1;
               end
               if (hit) begin
                  slot_calls[s] = 32'(clamp_sum(slot_calls[s], 1, COUNT_MAX));
                  slot_incl[s] = 48'(clamp_sum(slot_incl[s], incl, TIME_MAX));
                  slot_self[s] = 48'(clamp_sum(slot_self[s], slf, TIME_MAX));
                  r.count = slot_calls[s];
                  r.incl = slot_incl[s];
                  r.self_t = slot_self[s];
               end else begin
                  r.status = ctp_pkg::ST_FULL;
               end
               cap = (trace_cap_reg < RECORDS) ? trace_cap_reg : RECORDS;
               if (recs_taken < cap) begin
                  rec_key[recs_taken] = key;
                  rec_depth[recs_taken] = 7'(top);
                  rec_start[recs_taken] = ent - prof_t0;
                  rec_dur[recs_taken] = incl;
                  recs_taken++;
               end else begin
                  drops = 32'(clamp_sum(drops, 1, COUNT_MAX));
               end
               r.depth = 7'(top);
               r.key = key;
               r.tstart = ent - prof_t0;
               r.tdur = incl;
            end
         end
         ctp_pkg::FUNC_RDTAB: begin
            if (idx < SLOTS && slot_live[idx]) begin
               r.key = slot_id[idx];
               r.count = slot_calls[idx];
               r.incl = slot_incl[idx];
               r.self_t = slot_self[idx];
            end else begin
               r.status = ctp_pkg::ST_EMPTY;
            end
         end
         ctp_pkg::FUNC_RDTRC: begin
            if (idx < recs_taken) begin
               r.depth = rec_depth[idx];
               r.key = rec_key[idx];
               r.tstart = rec_start[idx];
               r.tdur = rec_dur[idx];
            end else begin
               r.status = ctp_pkg::ST_EMPTY;
            end
         end
         default: ;
      endcase
      r.active = prof_on;
      r.dropped = drops;
      expected_results.insert(expected_results.size(), r);
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at cycle %0d", field, got, want, cycles);
      mismatches++;
   endtask

   // Compare a result with the oldest expectation.
   task automatic check_result();
      profile_result_type e;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected result", rsp_status, 0);
         return;
      end
      e = expected_results.pop_front();
      results_seen++;
      if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
      if (rsp_active !== e.active) report_mismatch("active", rsp_active, e.active);
      if (rsp_nest_depth !== e.depth) report_mismatch("nest_depth", rsp_nest_depth, e.depth);
      if (rsp_entry_key !== e.key) report_mismatch("entry_key", rsp_entry_key, e.key);
      if (rsp_call_count !== e.count) report_mismatch("call_count", rsp_call_count, e.count);
      if (rsp_inclusive_ns !== e.incl)
         report_mismatch("inclusive_ns", rsp_inclusive_ns, e.incl);
      if (rsp_self_ns !== e.self_t) report_mismatch("self_ns", rsp_self_ns, e.self_t);
      if (rsp_trace_start_ns !== e.tstart)
         report_mismatch("trace_start_ns", rsp_trace_start_ns, e.tstart);
      if (rsp_trace_duration_ns !== e.tdur)
         report_mismatch("trace_duration_ns", rsp_trace_duration_ns, e.tdur);
      if (rsp_dropped_count !== e.dropped)
         report_mismatch("dropped_count", rsp_dropped_count, e.dropped);
   endtask

   // Monitor: check results, capture accepted items and register writes, watch the clock.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end else if (reset) begin
         trace_cap_reg = ctp_pkg::TRACE_LIMIT_RESET;
         prof_on = 0;
         prof_t0 = '0;
         clear_profile();
         item_taken = 0;
      end else begin
         if (rsp_valid === 1'b1) check_result();
         item_taken = start && !busy;
         if (item_taken)
            predict_profile(req_func, req_timestamp_ns, req_call_key, req_read_index);
         if (csr_valid && csr_ready) trace_cap_reg = csr_data;
      end
   end

   // Driver: present queued items on the falling edge and hold each until taken.
   always @(negedge clock) begin
      event_item_type it;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (pending_events.size() != 0 && $urandom_range(0, 99) >= gap_pct &&
             !(pending_events[0].hold && expected_results.size() != 0)) begin
            it = pending_events.pop_front();
            req_func <= it.func;
            req_timestamp_ns <= it.stamp;
            req_call_key <= it.key;
            req_read_index <= it.index;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   logic [47:0] gen_time;
   int          gen_depth;
   logic [15:0] key_pool[8];

   task automatic add_event(logic [2:0] f, logic [47:0] ts, logic [15:0] key,
                            logic [9:0] idx, bit hold = 0);
      event_item_type it;
      it = '{f, ts, key, idx, hold};
      pending_events.insert(pending_events.size(), it);
   endtask

   // Nesting sequences with random content plus some noise and broken sequences.
   task automatic add_random_events(int n);
      int roll;
      logic [15:0] key;
      logic [9:0]  idx;
      foreach (key_pool[i]) key_pool[i] = 16'($urandom);
      add_event(ctp_pkg::FUNC_START, gen_time, '0, '0);
      gen_depth = 0;
      repeat (n) begin
         gen_time += $urandom_range(0, 3000);
         if ($urandom_range(0, 99) < 3) gen_time = 48'({$urandom, $urandom});
         key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : 16'($urandom);
         idx = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 40)) : 10'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            add_event(ctp_pkg::FUNC_START, gen_time, key, idx);
            gen_depth = 0;
         end else if (roll < 4) begin
            add_event(ctp_pkg::FUNC_STOP, gen_time, key, idx);
         end else if (roll < 48 && gen_depth < 70) begin
            add_event(ctp_pkg::FUNC_ENTER, gen_time, key, idx);
            gen_depth++;
         end else if (roll < 86) begin
            add_event(ctp_pkg::FUNC_EXIT, gen_time, key, idx);
            if (gen_depth > 0) gen_depth--;
         end else if (roll < 92) begin
            add_event(ctp_pkg::FUNC_RDTAB, gen_time, key, idx, $urandom_range(0, 150) == 0);
         end else if (roll < 98) begin
            add_event(ctp_pkg::FUNC_RDTRC, gen_time, key, idx);
         end else begin
            add_event(($urandom_range(0, 1) != 0) ? FUNC_SPARE_A : FUNC_SPARE_B,
                      48'({$urandom, $urandom}), 16'($urandom), 10'($urandom));
         end
      end
   endtask

   task automatic write_trace_limit(logic [10:0] value);
      wait (pending_events.size() == 0 && expected_results.size() == 0 && !start);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      gen_time = 48'({$urandom, $urandom});

      // Directed: inactive and empty cases, wrap, saturation, nesting, readouts.
      write_trace_limit(11'd1024);
      gap_pct = 18;
      add_event(ctp_pkg::FUNC_ENTER, '0, '0, '0);
      add_event(ctp_pkg::FUNC_EXIT, TIME_MAX, 16'hFFFF, 10'h3FF);
      add_event(ctp_pkg::FUNC_RDTAB, '0, '0, '0);
      add_event(ctp_pkg::FUNC_RDTRC, '0, '0, 10'h3FF);
      add_event(FUNC_SPARE_A, TIME_MAX, 16'hFFFF, 10'h3FF);
      add_event(FUNC_SPARE_B, '0, '0, '0);
      add_event(ctp_pkg::FUNC_STOP, '0, '0, '0);
      add_event(ctp_pkg::FUNC_START, TIME_MAX - 48'd10, '0, '0);
      add_event(ctp_pkg::FUNC_ENTER, TIME_MAX - 48'd5, '0, '0);
      add_event(ctp_pkg::FUNC_ENTER, TIME_MAX, '0, '0);
      add_event(ctp_pkg::FUNC_EXIT, 48'd20, 16'h0000, '0);
      add_event(ctp_pkg::FUNC_EXIT, 48'd40, 16'hFFFF, '0, 1);
      // Two children of the longest duration saturate the parent's child time.
      add_event(ctp_pkg::FUNC_ENTER, 48'd100, '0, '0);
      add_event(ctp_pkg::FUNC_ENTER, 48'd200, '0, '0);
      add_event(ctp_pkg::FUNC_EXIT, 48'd199, 16'h5A5A, '0);
      add_event(ctp_pkg::FUNC_ENTER, 48'd300, '0, '0);
      add_event(ctp_pkg::FUNC_EXIT, 48'd299, 16'h5A5A, '0);
      add_event(ctp_pkg::FUNC_ENTER, 48'd400, '0, '0);
      add_event(ctp_pkg::FUNC_STOP, 48'd450, '0, '0);
      add_event(ctp_pkg::FUNC_ENTER, 48'd460, '0, '0);
      add_event(ctp_pkg::FUNC_EXIT, 48'd500, 16'hA5A5, '0);
      add_event(ctp_pkg::FUNC_EXIT, 48'd600, 16'h1234, '0);
      add_event(ctp_pkg::FUNC_RDTAB, '0, '0, 10'd2);
      add_event(ctp_pkg::FUNC_RDTRC, '0, '0, 10'd3);
      add_event(ctp_pkg::FUNC_RDTAB, '0, '0, 10'h3FF);
      add_random_events(150);

      // Stack overflow and underflow with tracing switched off.
      write_trace_limit(11'd0);
      add_event(ctp_pkg::FUNC_START, gen_time, '0, '0);
      repeat (66) add_event(ctp_pkg::FUNC_ENTER, gen_time + $urandom_range(0, 99), '0, '0);
      repeat (66) add_event(ctp_pkg::FUNC_EXIT, gen_time + 48'd5000, 16'($urandom), '0);
      add_random_events(100);

      // Key table filled past its capacity.
      write_trace_limit(11'd3);
      gap_pct = 45;
      add_event(ctp_pkg::FUNC_START, gen_time, '0, '0);
      for (int i = 0; i < 260; i++) begin
         add_event(ctp_pkg::FUNC_ENTER, gen_time + i, '0, '0);
         add_event(ctp_pkg::FUNC_EXIT, gen_time + 2 * i + 9, 16'(i * 251 + 7), '0);
      end
      add_event(ctp_pkg::FUNC_RDTAB, '0, '0, 10'd255);
      add_event(ctp_pkg::FUNC_RDTAB, '0, '0, 10'd256);
      add_event(ctp_pkg::FUNC_RDTRC, '0, '0, 10'd2);

      write_trace_limit(11'd2047);
      add_random_events(200);

      write_trace_limit(11'd5);
      gap_pct = 0;
      add_random_events(200);

      wait (pending_events.size() == 0 && expected_results.size() == 0 && !start);
      repeat (40) @(posedge clock);
      $display("Checked %0d results, %0d of them call exits, over five trace limit settings.",
               results_seen, exits_seen);
      $display("Covered stack overflow, table overflow, timer wrap, saturation and readouts.");
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/ctp_pkg.sv
sv/ctp_ram.sv
sv/ctp_ctrl.sv
sv/ctp_dp.sv
sv/call_time_profiler_unit.sv
bench/tb_call_time_profiler_unit.sv
